// ===== src/source_text_lexer_macros.svh =====
// assertion macros shared by the lexer modules
`ifndef SOURCE_TEXT_LEXER_MACROS_SVH
`define SOURCE_TEXT_LEXER_MACROS_SVH

// condition holds at every edge out of reset
`define STL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// same-cycle implication
`define STL_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/stl_pkg.sv =====
// types, constants and helper functions of the source text lexer
`timescale 1ns / 1ps

package stl_pkg;

    localparam int POSITION_BITS = 16;
    localparam int LENGTH_BITS   = 16;
    localparam int KIND_W        = 5;
    localparam int FIELD_W       = 16;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef logic [POSITION_BITS-1:0] t_pos;
    typedef logic [LENGTH_BITS-1:0]   t_len;
    typedef logic [KIND_W-1:0]        t_kind;

    // token kinds
    localparam t_kind K_NEWLINE = 5'd0;
    localparam t_kind K_SEMI    = 5'd1;
    localparam t_kind K_EQ      = 5'd2;
    localparam t_kind K_LPAR    = 5'd3;
    localparam t_kind K_RPAR    = 5'd4;
    localparam t_kind K_BANG    = 5'd5;
    localparam t_kind K_TILDE   = 5'd6;
    localparam t_kind K_AMP     = 5'd7;
    localparam t_kind K_BAR     = 5'd8;
    localparam t_kind K_CARET   = 5'd9;
    localparam t_kind K_AT      = 5'd10;
    localparam t_kind K_DOLLAR  = 5'd11;
    localparam t_kind K_STAR    = 5'd12;
    localparam t_kind K_POW     = 5'd13;
    localparam t_kind K_MINUS   = 5'd14;
    localparam t_kind K_DEC     = 5'd15;
    localparam t_kind K_PLUS    = 5'd16;
    localparam t_kind K_INC     = 5'd17;
    localparam t_kind K_LT      = 5'd18;
    localparam t_kind K_SLL     = 5'd19;
    localparam t_kind K_GT      = 5'd20;
    localparam t_kind K_SRA     = 5'd21;
    localparam t_kind K_SRL     = 5'd22;
    localparam t_kind K_DIV     = 5'd23;
    localparam t_kind K_COMMENT = 5'd24;
    localparam t_kind K_NUMBER  = 5'd25;
    localparam t_kind K_ID      = 5'd26;
    localparam t_kind K_END     = 5'd27;

    // characters
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_UP_B   = 8'h42;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] line;
        logic [FIELD_W-1:0] column;
        logic [FIELD_W-1:0] length;
        logic               last;
    } t_token;

    // up to two tokens handed to the result queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_single;

    function automatic t_single single_kind(input logic [7:0] b);
        t_single s;
        s.hit = 1'b1;
        case (b)
            CH_SEMI:   s.kind = K_SEMI;
            CH_EQ:     s.kind = K_EQ;
            CH_LPAR:   s.kind = K_LPAR;
            CH_RPAR:   s.kind = K_RPAR;
            CH_BANG:   s.kind = K_BANG;
            CH_TILDE:  s.kind = K_TILDE;
            CH_AMP:    s.kind = K_AMP;
            CH_BAR:    s.kind = K_BAR;
            CH_CARET:  s.kind = K_CARET;
            CH_AT:     s.kind = K_AT;
            CH_DOLLAR: s.kind = K_DOLLAR;
            default: begin
                s.hit  = 1'b0;
                s.kind = K_NEWLINE;
            end
        endcase
        return s;
    endfunction

    function automatic logic [7:0] pair_char(input t_kind k);
        logic [7:0] c;
        case (k)
            K_STAR:  c = CH_STAR;
            K_MINUS: c = CH_MINUS;
            K_PLUS:  c = CH_PLUS;
            default: c = CH_LT;
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b inside {[CH_LO_A:CH_LO_Z]}) || (b inside {[CH_UP_A:CH_UP_Z]}) ||
               (b == CH_UNDER);
    endfunction

    function automatic t_pos sat_pos(input t_pos v);
        return (&v) ? v : t_pos'(v + 1'b1);
    endfunction

    function automatic t_len sat_len(input t_len v);
        return (&v) ? v : t_len'(v + 1'b1);
    endfunction

    function automatic t_token make_tok(input t_kind k, input t_pos line, input t_pos col,
                                        input t_len len);
        t_token t;
        t.kind   = k;
        t.line   = FIELD_W'(line);
        t.column = FIELD_W'(col);
        t.length = FIELD_W'(len);
        t.last   = 1'b0;
        return t;
    endfunction

endpackage

// ===== src/stl_stream_if.sv =====
// byte and token stream interfaces of the source text lexer
`timescale 1ns / 1ps

interface stl_byte_if import stl_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source(output valid, text_byte, end_of_text, input ready);
    modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

interface stl_token_if import stl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  token_kind;
    logic [FIELD_W-1:0] token_line;
    logic [FIELD_W-1:0] token_column;
    logic [FIELD_W-1:0] token_length;
    logic               last_of_run;

    modport source(output valid, token_kind, token_line, token_column, token_length,
                   last_of_run, input ready);
    modport sink(input valid, token_kind, token_line, token_column, token_length,
                 last_of_run, output ready);
endinterface

// ===== src/stl_lex_core.sv =====
// input register and single-pass lexer state update
`timescale 1ns / 1ps
`include "source_text_lexer_macros.svh"

module stl_lex_core import stl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stl_byte_if.sink   i_text,
    input  logic       i_room,
    output t_push      o_push
);

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_PAIR    = 4'd1;
    localparam logic [3:0] M_GT1     = 4'd2;
    localparam logic [3:0] M_GT2     = 4'd3;
    localparam logic [3:0] M_SLASH   = 4'd4;
    localparam logic [3:0] M_COMMENT = 4'd5;
    localparam logic [3:0] M_ZERO    = 4'd6;
    localparam logic [3:0] M_NUM     = 4'd7;
    localparam logic [3:0] M_ID      = 4'd8;

    localparam t_pos POS_ONE = t_pos'(1);
    localparam t_len LEN_ONE = t_len'(1);

    logic       r_vld;
    logic [7:0] r_byte;
    logic       r_eot;

    logic [3:0] r_mode, n_mode;
    t_kind      r_pend_kind, n_pend_kind;
    t_pos       r_start_col, n_start_col;
    t_len       r_pend_len, n_pend_len;
    t_pos       r_line, n_line;
    t_pos       r_col, n_col;
    t_kind      r_last_kind, n_last_kind;
    logic       r_any, n_any;

    logic    consume;
    logic    taken;
    logic    flush;
    logic    a_vld, b_vld;
    t_token  tok_a, tok_b;
    t_token  flush_tok;
    t_len    len_inc;
    t_kind   last_k;
    t_single sk;

    assign consume      = r_vld && i_room;
    assign i_text.ready = !r_vld || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_text.ready) begin
            r_vld <= i_text.valid;
        end
        if (i_text.ready && i_text.valid) begin
            r_byte <= i_text.text_byte;
            r_eot  <= i_text.end_of_text;
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_pend_kind = r_pend_kind;
        n_start_col = r_start_col;
        n_pend_len  = r_pend_len;
        n_line      = r_line;
        n_col       = r_col;
        taken       = 1'b0;
        flush       = 1'b0;
        a_vld       = 1'b0;
        b_vld       = 1'b0;
        tok_a       = '0;
        tok_b       = '0;
        len_inc     = sat_len(r_pend_len);
        flush_tok   = make_tok(r_pend_kind, r_line, r_start_col, r_pend_len);
        sk          = single_kind(r_byte);
        last_k      = r_last_kind;

        if (r_eot) begin
            if (r_mode != M_IDLE) begin
                a_vld  = 1'b1;
                tok_a  = flush_tok;
                last_k = r_pend_kind;
            end
            if (!(r_any || a_vld) || (last_k != K_NEWLINE && last_k != K_SEMI)) begin
                b_vld = 1'b1;
                tok_b = make_tok(K_END, r_line, '0, '0);
            end
            n_mode      = M_IDLE;
            n_pend_kind = K_NEWLINE;
            n_start_col = '0;
            n_pend_len  = '0;
            n_line      = POS_ONE;
            n_col       = POS_ONE;
        end else begin
            // try to extend the pending token first
            case (r_mode)
                M_IDLE: begin
                end
                M_PAIR: begin
                    if (r_byte == pair_char(r_pend_kind)) begin
                        taken  = 1'b1;
                        a_vld  = 1'b1;
                        tok_a  = make_tok(t_kind'(r_pend_kind + 1'b1), r_line, r_start_col,
                                          len_inc);
                        n_mode = M_IDLE;
                    end else begin
                        flush = 1'b1;
                    end
                end
                M_GT1: begin
                    if (r_byte == CH_GT) begin
                        taken       = 1'b1;
                        n_pend_kind = K_SRA;
                        n_pend_len  = len_inc;
                        n_mode      = M_GT2;
                    end else begin
                        flush = 1'b1;
                    end
                end
                M_GT2: begin
                    if (r_byte == CH_GT) begin
                        taken  = 1'b1;
                        a_vld  = 1'b1;
                        tok_a  = make_tok(K_SRL, r_line, r_start_col, len_inc);
                        n_mode = M_IDLE;
                    end else begin
                        flush = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (r_byte == CH_SLASH) begin
                        taken       = 1'b1;
                        n_pend_kind = K_COMMENT;
                        n_pend_len  = len_inc;
                        n_mode      = M_COMMENT;
                    end else begin
                        flush = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (r_byte != CH_NL) begin
                        taken      = 1'b1;
                        n_pend_len = len_inc;
                    end else begin
                        flush = 1'b1;
                    end
                end
                M_ZERO: begin
                    if (r_byte == CH_LO_X || r_byte == CH_UP_X || r_byte == CH_LO_B ||
                        r_byte == CH_UP_B || is_digit(r_byte)) begin
                        taken      = 1'b1;
                        n_pend_len = len_inc;
                        n_mode     = M_NUM;
                    end else begin
                        flush = 1'b1;
                    end
                end
                M_NUM: begin
                    if (is_digit(r_byte)) begin
                        taken      = 1'b1;
                        n_pend_len = len_inc;
                    end else begin
                        flush = 1'b1;
                    end
                end
                M_ID: begin
                    if (is_alpha(r_byte) || is_digit(r_byte)) begin
                        taken      = 1'b1;
                        n_pend_len = len_inc;
                    end else begin
                        flush = 1'b1;
                    end
                end
                default: begin
                    n_mode = M_IDLE;
                end
            endcase

            if (flush) begin
                a_vld  = 1'b1;
                tok_a  = flush_tok;
                n_mode = M_IDLE;
            end

            // byte not absorbed: lex it afresh
            if (!taken) begin
                if (r_byte == CH_NL) begin
                    b_vld = 1'b1;
                    tok_b = make_tok(K_NEWLINE, r_line, r_col, LEN_ONE);
                end else if (sk.hit) begin
                    b_vld = 1'b1;
                    tok_b = make_tok(sk.kind, r_line, r_col, LEN_ONE);
                end else begin
                    if (r_byte == CH_STAR) begin
                        n_mode      = M_PAIR;
                        n_pend_kind = K_STAR;
                    end else if (r_byte == CH_MINUS) begin
                        n_mode      = M_PAIR;
                        n_pend_kind = K_MINUS;
                    end else if (r_byte == CH_PLUS) begin
                        n_mode      = M_PAIR;
                        n_pend_kind = K_PLUS;
                    end else if (r_byte == CH_LT) begin
                        n_mode      = M_PAIR;
                        n_pend_kind = K_LT;
                    end else if (r_byte == CH_GT) begin
                        n_mode      = M_GT1;
                        n_pend_kind = K_GT;
                    end else if (r_byte == CH_SLASH) begin
                        n_mode      = M_SLASH;
                        n_pend_kind = K_DIV;
                    end else if (r_byte == CH_ZERO) begin
                        n_mode      = M_ZERO;
                        n_pend_kind = K_NUMBER;
                    end else if (is_digit(r_byte)) begin
                        n_mode      = M_NUM;
                        n_pend_kind = K_NUMBER;
                    end else if (is_alpha(r_byte)) begin
                        n_mode      = M_ID;
                        n_pend_kind = K_ID;
                    end
                    if (r_byte == CH_STAR || r_byte == CH_MINUS || r_byte == CH_PLUS ||
                        r_byte == CH_LT || r_byte == CH_GT || r_byte == CH_SLASH ||
                        is_digit(r_byte) || is_alpha(r_byte)) begin
                        n_start_col = r_col;
                        n_pend_len  = LEN_ONE;
                    end
                end
            end

            if (r_byte == CH_NL) begin
                n_line = sat_pos(r_line);
                n_col  = POS_ONE;
            end else begin
                n_col = sat_pos(r_col);
            end
        end
    end

    // end of text returns everything to reset values
    assign n_last_kind = r_eot ? K_NEWLINE :
                         b_vld ? tok_b.kind : (a_vld ? tok_a.kind : r_last_kind);
    assign n_any       = r_eot ? 1'b0 : (r_any || a_vld || b_vld);

    // compact the two slots into the push word, last flag on the final one
    always_comb begin
        o_push = '0;
        if (consume) begin
            if (a_vld && b_vld) begin
                o_push.cnt       = 2'd2;
                o_push.tok0      = tok_a;
                o_push.tok1      = tok_b;
                o_push.tok1.last = 1'b1;
            end else if (a_vld) begin
                o_push.cnt       = 2'd1;
                o_push.tok0      = tok_a;
                o_push.tok0.last = 1'b1;
            end else if (b_vld) begin
                o_push.cnt       = 2'd1;
                o_push.tok0      = tok_b;
                o_push.tok0.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_pend_kind <= K_NEWLINE;
            r_start_col <= '0;
            r_pend_len  <= '0;
            r_line      <= POS_ONE;
            r_col       <= POS_ONE;
            r_last_kind <= K_NEWLINE;
            r_any       <= 1'b0;
        end else if (consume) begin
            r_mode      <= n_mode;
            r_pend_kind <= n_pend_kind;
            r_start_col <= n_start_col;
            r_pend_len  <= n_pend_len;
            r_line      <= n_line;
            r_col       <= n_col;
            r_last_kind <= n_last_kind;
            r_any       <= n_any;
        end
    end

    `STL_ASSERT_NEXT(a_eot_restart, consume && r_eot, (r_mode == M_IDLE) && (r_line == POS_ONE) && (r_col == POS_ONE) && !r_any, "lexer state not restarted after end of text")
    `STL_ASSERT_IMPLY(a_two_last, o_push.cnt == 2'd2, o_push.tok1.last && !o_push.tok0.last, "last flag misplaced on a double push")
    `STL_ASSERT_IMPLY(a_comment_kind, r_mode == M_COMMENT, r_pend_kind == K_COMMENT, "comment mode with wrong pending kind")

endmodule

// ===== src/stl_result_fifo.sv =====
// small result queue taking up to two tokens per cycle and sending one while the sink is ready
`timescale 1ns / 1ps
`include "source_text_lexer_macros.svh"

module stl_result_fifo import stl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_push       i_push,
    output logic        o_room,
    stl_token_if.source o_token
);

    t_token            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [PTR_W-1:0]  wr_next;
    logic              pop;
    t_token            head;

    assign head    = r_mem[r_rd];
    assign pop     = o_token.valid && o_token.ready;
    assign wr_next = PTR_W'(r_wr + 1'b1);
    assign o_room  = r_count <= CNT_W'(FIFO_DEPTH - 2);

    assign o_token.valid        = r_count != '0;
    assign o_token.token_kind   = head.kind;
    assign o_token.token_line   = head.line;
    assign o_token.token_column = head.column;
    assign o_token.token_length = head.length;
    assign o_token.last_of_run  = head.last;

    assign n_wr    = PTR_W'(r_wr + i_push.cnt);
    assign n_rd    = pop ? PTR_W'(r_rd + 1'b1) : r_rd;
    assign n_count = CNT_W'(r_count + CNT_W'(i_push.cnt) - CNT_W'(pop));

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.tok0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_next] <= i_push.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `STL_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(FIFO_DEPTH), "result queue count above depth")
    `STL_ASSERT_IMPLY(a_push_room, i_push.cnt != 2'd0, r_count <= CNT_W'(FIFO_DEPTH - 2), "push into result queue without room")

endmodule

// ===== src/source_text_lexer.sv =====
// throughput: one byte per cycle while the result queue has room; a byte waits in the
// input register and its tokens in the queue, which they leave one word per cycle while
// the sink is ready, so a byte that closes a pending token and starts a single-character
// one yields two words; the four-entry queue and the input register decouple the sides
// reset (synchronous, active low): line and column to 1, no pending token, queue empty
`timescale 1ns / 1ps

module source_text_lexer import stl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stl_byte_if.sink    i_text,
    stl_token_if.source o_token
);

    t_push push;
    logic  room;

    stl_lex_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (i_text),
        .i_room  (room),
        .o_push  (push)
    );

    stl_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_token (o_token)
    );

endmodule
